@@ hdl/fdtd_pkg.sv @@
// ----------------------------------------------------------------------------
// fdtd_pkg
// Shared types, register indexes and fixed-point helpers for the 1-D FDTD core.
// ----------------------------------------------------------------------------
package fdtd_pkg;

  // Configuration register indexes.
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 25;
  localparam logic [CFG_IW-1:0] CFG_DIEL_START  = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_GA          = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_GB          = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_GC          = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_RELAX       = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_SRC_CELL    = 3'd5;
  localparam logic [CFG_IW-1:0] CFG_REF_CELL    = 3'd6;
  localparam logic [CFG_IW-1:0] CFG_REF_STEPS   = 3'd7;

  // Stream widths.
  localparam int IN_DW  = 200;
  localparam int OUT_DW = 240;
  localparam int TRIG_W = 26;
  localparam int DFT_W  = 48;

  typedef logic signed [31:0] grid_t;
  typedef logic signed [DFT_W-1:0] dft_t;

  // One grid cell as stored in the field memory.
  typedef struct packed {
    grid_t d;
    grid_t e;
    grid_t h;
    grid_t i;
    grid_t s;
  } cell_row_t;

  // Request to the shared multiply-accumulate unit.
  typedef struct packed {
    logic               en;
    logic               acc;
    logic signed [33:0] a;
    logic signed [25:0] b;
  } mul_req_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_P1_RD,
    ST_P1_LD,
    ST_P1_E0,
    ST_P1_E1,
    ST_P1_I0,
    ST_P1_I1,
    ST_P1_S1,
    ST_P1_S2,
    ST_P1_DM,
    ST_P1_DA,
    ST_P1_WR,
    ST_P2_RD0,
    ST_P2_LD0,
    ST_P2_RD,
    ST_P2_LD,
    ST_OUT_RD,
    ST_OUT_LD
  } state_t;

  // Round a Q.24 product to nearest, ties toward +inf.
  function automatic logic signed [36:0] rnd24(input logic signed [60:0] p);
    logic signed [60:0] t;
    t = p + 61'sd8388608;
    return t[60:24];
  endfunction

  // Halve with rounding, ties up.
  function automatic logic signed [33:0] half(input logic signed [33:0] x);
    logic signed [33:0] t;
    t = x + 34'sd1;
    return t >>> 1;
  endfunction

  function automatic grid_t sat32(input logic signed [39:0] v);
    if (v > 40'sd2147483647) return 32'sh7fffffff;
    if (v < -40'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic dft_t sat48(input logic signed [49:0] v);
    if (v > 50'sd140737488355327) return 48'sh7fffffffffff;
    if (v < -50'sd140737488355328) return 48'sh800000000000;
    return v[47:0];
  endfunction

endpackage

@@ hdl/fdtd_1d_debye_step_with_dft_core.sv @@
// ----------------------------------------------------------------------------
// fdtd_1d_debye_step_with_dft_core
// One-dimensional FDTD grid with a Debye slab and running per-cell DFTs.
// ----------------------------------------------------------------------------
// A step beat (tuser = 0) advances the grid by one time step; a read beat
// (tuser = 1) only reports. Every beat returns one result beat about the
// chosen cell. All multiplications run through one shared multiplier under a
// sequencer. A step makes two sweeps over the cells: the first computes
// the field and loss integrals, then one multiply per DFT term (the last
// cell skips the integrals); the second does the magnetic update. A new
// beat is taken only once the result of the previous one has been loaded
// into the output register. After reset the block clears its cell
// memories before it takes the first beat; configuration writes are
// accepted at any time.
module fdtd_1d_debye_step_with_dft_core #(
  parameter int CELLS = 256,
  parameter int FREQS = 3
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // Input stream.
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // tdata, low bit up: source_value[31:0], cos_f0, sin_f0, cos_f1, sin_f1,
  // cos_f2, sin_f2 (26 bits each), cell_index[7:0], freq_select[1:0], pad.
  input  logic [fdtd_pkg::IN_DW-1:0]  in_tdata,
  // tuser: mode.
  input  logic                        in_tuser,
  // Result stream.
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // tdata, low bit up: field_value[31:0], dft_real[47:0], dft_imag[47:0],
  // ref_real[47:0], ref_imag[47:0], step_number[15:0].
  output logic [fdtd_pkg::OUT_DW-1:0] out_tdata,
  // Configuration writes.
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [fdtd_pkg::CFG_IW-1:0] cfg_index,
  input  logic [fdtd_pkg::CFG_DW-1:0] cfg_data
);
  import fdtd_pkg::*;

  localparam int AW  = $clog2(CELLS);
  localparam int FW  = (FREQS > 1) ? $clog2(FREQS) : 1;
  localparam int DRW = FREQS * 2 * DFT_W;

  // Configuration registers.
  logic [8:0]  diel_r;
  logic [24:0] ga_r, gb_r, gc_r, relax_r;
  logic [7:0]  srcc_r, refc_r;
  logic [15:0] refsteps_r;

  // Control.
  state_t      state_r, state_nxt;
  logic [AW-1:0] cnt_r;
  logic [FW-1:0] f_r;
  logic        part_r;
  logic [15:0] step_r;
  logic        ref_act_r;
  logic        out_valid_r;
  logic [OUT_DW-1:0] out_data_r;

  // Item payload.
  grid_t       src_val_r;
  logic signed [TRIG_W-1:0] cs_r [FREQS];
  logic signed [TRIG_W-1:0] sn_r [FREQS];
  logic signed [TRIG_W-1:0] cos_x [FREQS];
  logic signed [TRIG_W-1:0] sin_x [FREQS];
  logic [7:0]  cell_r;
  logic [1:0]  fs_r;

  // Working cell.
  grid_t       d_r, e_r, h_r, i_r, s_r, hprev_r, prev_e_r;
  grid_t       bh0_r, bh1_r, bh2_r, bh3_r;
  cell_row_t   row_r;
  logic [DRW-1:0] dft_row_r;
  dft_t        ref_re_r [FREQS];
  dft_t        ref_im_r [FREQS];

  // Memories.
  cell_row_t   fmem [CELLS];
  logic [DRW-1:0] dmem [CELLS];
  cell_row_t   fm_rdata_r;
  logic [DRW-1:0] dm_rdata_r;
  logic        rd_en, fm_we, dm_we;
  logic [AW-1:0] raddr, waddr;
  cell_row_t   fm_wdata;

  // Multiplier.
  mul_req_t    mreq;
  logic signed [60:0] mul_p;

  // Combinational helpers.
  logic        in_acc, last_cell, src_hit, ref_hit, slab, cell_ok, fs_ok;
  logic [15:0] step_inc;
  grid_t       d1, d2, e_wr, h_new;
  logic signed [36:0] prod_rnd;
  int          slot;
  dft_t        slot_old, slot_new, ref_old, ref_new;
  logic [FW-1:0] rix;
  dft_t        ref_re_sel, ref_im_sel;

  fdtd_mul u_mul (
    .clk   (clk),
    .req   (mreq),
    .acc_r (mul_p)
  );

  // Input unpacking of the phase samples; extra frequencies see zero.
  for (genvar g = 0; g < FREQS; g++) begin : g_trig
    if (g < 3) begin : g_live
      assign cos_x[g] = in_tdata[32 + 52*g +: TRIG_W];
      assign sin_x[g] = in_tdata[58 + 52*g +: TRIG_W];
    end else begin : g_zero
      assign cos_x[g] = '0;
      assign sin_x[g] = '0;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Datapath decodes.
  assign step_inc  = (step_r == 16'hffff) ? step_r : step_r + 16'd1;
  assign last_cell = (cnt_r == AW'(CELLS - 1));
  assign src_hit   = (32'(srcc_r) < CELLS) && (32'(srcc_r) == 32'(cnt_r));
  assign ref_hit   = ref_act_r && (32'(refc_r) == 32'(cnt_r));
  assign slab      = (32'(cnt_r) >= 32'(diel_r));
  assign cell_ok   = (32'(cell_r) < CELLS);
  assign fs_ok     = (32'(fs_r) < FREQS);

  assign d1 = sat32(40'(fm_rdata_r.d) + 40'(half(34'(hprev_r) - 34'(fm_rdata_r.h))));
  assign d2 = src_hit ? sat32(40'(d1) + 40'(src_val_r)) : d1;
  assign h_new = sat32(40'(row_r.h) + 40'(half(34'(row_r.e) - 34'(fm_rdata_r.e))));
  assign prod_rnd = rnd24(mul_p);

  always_comb begin
    if (cnt_r == '0) begin
      e_wr = bh1_r;
    end else if (last_cell) begin
      e_wr = bh3_r;
    end else begin
      e_wr = e_r;
    end
  end

  // DFT slot arithmetic: real adds cos*E, imaginary subtracts sin*E.
  assign rix        = (state_r == ST_OUT_LD) ? FW'(fs_r) : f_r;
  assign ref_re_sel = ref_re_r[rix];
  assign ref_im_sel = ref_im_r[rix];
  assign slot       = 32'(f_r) * 2 * DFT_W + (part_r ? DFT_W : 0);
  assign slot_old   = dft_row_r[slot +: DFT_W];
  assign ref_old    = part_r ? ref_im_sel : ref_re_sel;
  assign slot_new   = part_r ? sat48(50'(slot_old) - 50'(prod_rnd))
                             : sat48(50'(slot_old) + 50'(prod_rnd));
  assign ref_new    = part_r ? sat48(50'(ref_old) - 50'(prod_rnd))
                             : sat48(50'(ref_old) + 50'(prod_rnd));

  // Memory ports.
  always_ff @(posedge clk) begin
    if (fm_we) begin
      fmem[waddr] <= fm_wdata;
    end
    if (dm_we) begin
      dmem[waddr] <= (state_r == ST_CLEAR) ? '0 : dft_row_r;
    end
    if (rd_en) begin
      fm_rdata_r <= fmem[raddr];
      dm_rdata_r <= dmem[raddr];
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequencer: next state, memory and multiplier controls.
  always_comb begin
    state_nxt = state_r;
    rd_en     = 1'b0;
    fm_we     = 1'b0;
    dm_we     = 1'b0;
    raddr     = cnt_r;
    waddr     = cnt_r;
    fm_wdata  = '0;
    mreq      = '0;
    case (state_r)
      ST_CLEAR: begin
        fm_we = 1'b1;
        dm_we = 1'b1;
        if (last_cell) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) state_nxt = in_tuser ? ST_OUT_RD : ST_P1_RD;
      end
      ST_P1_RD: begin
        rd_en     = 1'b1;
        state_nxt = ST_P1_LD;
      end
      ST_P1_LD: begin
        state_nxt = last_cell ? ST_P1_DM : ST_P1_E0;
      end
      ST_P1_E0: begin
        mreq.en   = 1'b1;
        mreq.a    = 34'(d_r) - 34'(i_r) - 34'(s_r);
        mreq.b    = slab ? $signed({1'b0, ga_r}) : 26'sd16777216;
        state_nxt = ST_P1_E1;
      end
      ST_P1_E1: begin
        state_nxt = ST_P1_I0;
      end
      ST_P1_I0: begin
        mreq.en   = 1'b1;
        mreq.a    = 34'(e_r);
        mreq.b    = slab ? $signed({1'b0, gb_r}) : 26'sd0;
        state_nxt = ST_P1_I1;
      end
      ST_P1_I1: begin
        mreq.en   = 1'b1;
        mreq.a    = 34'(s_r);
        mreq.b    = $signed({1'b0, relax_r});
        state_nxt = ST_P1_S1;
      end
      ST_P1_S1: begin
        mreq.en   = 1'b1;
        mreq.acc  = 1'b1;
        mreq.a    = 34'(e_r);
        mreq.b    = slab ? $signed({1'b0, gc_r}) : 26'sd0;
        state_nxt = ST_P1_S2;
      end
      ST_P1_S2: begin
        state_nxt = ST_P1_DM;
      end
      ST_P1_DM: begin
        mreq.en   = 1'b1;
        mreq.a    = 34'(e_r);
        mreq.b    = part_r ? sn_r[f_r] : cs_r[f_r];
        state_nxt = ST_P1_DA;
      end
      ST_P1_DA: begin
        state_nxt = (part_r && f_r == FW'(FREQS - 1)) ? ST_P1_WR : ST_P1_DM;
      end
      ST_P1_WR: begin
        fm_we     = 1'b1;
        dm_we     = 1'b1;
        fm_wdata  = '{d: d_r, e: e_wr, h: h_r, i: i_r, s: s_r};
        state_nxt = last_cell ? ST_P2_RD0 : ST_P1_RD;
      end
      ST_P2_RD0: begin
        rd_en     = 1'b1;
        state_nxt = ST_P2_LD0;
      end
      ST_P2_LD0: begin
        state_nxt = ST_P2_RD;
      end
      ST_P2_RD: begin
        rd_en     = 1'b1;
        raddr     = cnt_r + AW'(1);
        state_nxt = ST_P2_LD;
      end
      ST_P2_LD: begin
        fm_we     = 1'b1;
        fm_wdata  = row_r;
        fm_wdata.h = h_new;
        state_nxt = (cnt_r == AW'(CELLS - 2)) ? ST_OUT_RD : ST_P2_RD;
      end
      ST_OUT_RD: begin
        rd_en     = 1'b1;
        raddr     = AW'(cell_r);
        state_nxt = ST_OUT_LD;
      end
      ST_OUT_LD: begin
        if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diel_r     <= 9'd256;
      ga_r       <= 25'd16777216;
      gb_r       <= '0;
      gc_r       <= '0;
      relax_r    <= '0;
      srcc_r     <= 8'd5;
      refc_r     <= 8'd10;
      refsteps_r <= 16'd100;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DIEL_START: diel_r     <= cfg_data[8:0];
        CFG_GA:         ga_r       <= cfg_data;
        CFG_GB:         gb_r       <= cfg_data;
        CFG_GC:         gc_r       <= cfg_data;
        CFG_RELAX:      relax_r    <= cfg_data;
        CFG_SRC_CELL:   srcc_r     <= cfg_data[7:0];
        CFG_REF_CELL:   refc_r     <= cfg_data[7:0];
        CFG_REF_STEPS:  refsteps_r <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  // Boundary history and reference sums start at zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bh0_r <= '0;
      bh1_r <= '0;
      bh2_r <= '0;
      bh3_r <= '0;
      for (int k = 0; k < FREQS; k++) begin
        ref_re_r[k] <= '0;
        ref_im_r[k] <= '0;
      end
    end else begin
      if (state_r == ST_P1_DA && ref_hit) begin
        if (part_r) begin
          ref_im_r[f_r] <= ref_new;
        end else begin
          ref_re_r[f_r] <= ref_new;
        end
      end
      // Two-step edge history, shifted as cells 1 and CELLS-1 are written.
      if (state_r == ST_P1_WR && cnt_r == AW'(1)) begin
        bh1_r <= bh0_r;
        bh0_r <= e_r;
      end
      if (state_r == ST_P1_WR && last_cell) begin
        bh3_r <= bh2_r;
        bh2_r <= prev_e_r;
      end
    end
  end

  // Sequencer counters and the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      f_r         <= '0;
      part_r      <= 1'b0;
      step_r      <= '0;
      ref_act_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && state_r != ST_OUT_LD) out_valid_r <= 1'b0;
      case (state_r)
        ST_CLEAR: begin
          cnt_r <= last_cell ? '0 : cnt_r + AW'(1);
        end
        ST_IDLE: begin
          if (in_acc && !in_tuser) begin
            step_r    <= step_inc;
            ref_act_r <= (step_inc < refsteps_r);
            cnt_r     <= '0;
          end
        end
        ST_P1_LD: begin
          f_r    <= '0;
          part_r <= 1'b0;
        end
        ST_P1_DA: begin
          part_r <= ~part_r;
          if (part_r) f_r <= f_r + FW'(1);
        end
        ST_P1_WR: begin
          cnt_r <= last_cell ? '0 : cnt_r + AW'(1);
        end
        ST_P2_LD: begin
          cnt_r <= cnt_r + AW'(1);
        end
        ST_OUT_LD: begin
          if (!out_valid_r || out_tready) out_valid_r <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          src_val_r <= in_tdata[31:0];
          cell_r    <= in_tdata[195:188];
          fs_r      <= in_tdata[197:196];
          hprev_r   <= '0;
          for (int k = 0; k < FREQS; k++) begin
            cs_r[k] <= cos_x[k];
            sn_r[k] <= sin_x[k];
          end
        end
      end
      ST_P1_LD: begin
        d_r       <= d2;
        e_r       <= fm_rdata_r.e;
        h_r       <= fm_rdata_r.h;
        i_r       <= fm_rdata_r.i;
        s_r       <= fm_rdata_r.s;
        hprev_r   <= fm_rdata_r.h;
        dft_row_r <= dm_rdata_r;
      end
      ST_P1_E1: begin
        e_r <= sat32(40'(prod_rnd));
      end
      ST_P1_I1: begin
        i_r <= sat32(40'(i_r) + 40'(prod_rnd));
      end
      ST_P1_S2: begin
        s_r <= sat32(40'(prod_rnd));
      end
      ST_P1_DA: begin
        dft_row_r[slot +: DFT_W] <= slot_new;
      end
      ST_P1_WR: begin
        prev_e_r <= e_r;
      end
      ST_P2_LD0: begin
        row_r <= fm_rdata_r;
      end
      ST_P2_LD: begin
        row_r <= fm_rdata_r;
      end
      ST_OUT_LD: begin
        if (!out_valid_r || out_tready) begin
          out_data_r[31:0]    <= cell_ok ? fm_rdata_r.e : '0;
          out_data_r[79:32]   <= (cell_ok && fs_ok)
                                 ? dm_rdata_r[32'(fs_r) * 2 * DFT_W +: DFT_W] : '0;
          out_data_r[127:80]  <= (cell_ok && fs_ok)
                                 ? dm_rdata_r[32'(fs_r) * 2 * DFT_W + DFT_W +: DFT_W] : '0;
          out_data_r[175:128] <= fs_ok ? ref_re_sel : '0;
          out_data_r[223:176] <= fs_ok ? ref_im_sel : '0;
          out_data_r[239:224] <= step_r;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ hdl/fdtd_mul.sv @@
// ----------------------------------------------------------------------------
// fdtd_mul
// Shared signed multiply-accumulate unit with a registered result.
// ----------------------------------------------------------------------------
module fdtd_mul (
  input  logic                clk,
  input  fdtd_pkg::mul_req_t  req,
  output logic signed [60:0]  acc_r
);
  import fdtd_pkg::*;

  logic signed [59:0] prod;
  logic signed [60:0] acc_nxt;

  // Product, optionally added to the previous result.
  assign prod    = req.a * req.b;
  assign acc_nxt = 61'(prod) + (req.acc ? acc_r : 61'sd0);

  always_ff @(posedge clk) begin
    if (req.en) begin
      acc_r <= acc_nxt;
    end
  end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 1-D FDTD core with Debye slab and running DFTs.
// ----------------------------------------------------------------------------
// Step and read beats go into the core with random gaps. A behavioral grid
// model in this file predicts every result beat. A checker compares each
// result field by field with the oldest prediction. Between phases the
// register set is rewritten while the core is idle, extremes included.
module tb_top;
  import fdtd_pkg::*;

  localparam int NCELL = 256;
  localparam int NFREQ = 3;
  localparam longint ONE = 64'sd16777216;
  localparam longint HALF_LSB = 64'sd8388608;
  localparam longint TRIG_MAX = 64'sd16777216;
  localparam logic MODE_STEP = 1'b0;
  localparam logic MODE_READ = 1'b1;

  // Input beat fields, low bit last.
  typedef struct packed {
    logic [1:0]         fsel;
    logic [7:0]         cell_idx;
    logic signed [25:0] s2;
    logic signed [25:0] c2;
    logic signed [25:0] s1;
    logic signed [25:0] c1;
    logic signed [25:0] s0;
    logic signed [25:0] c0;
    logic signed [31:0] src;
  } grid_item_t;

  // Result beat fields, low bit last.
  typedef struct packed {
    logic [15:0]        steps;
    logic signed [47:0] rimag;
    logic signed [47:0] rreal;
    logic signed [47:0] dimag;
    logic signed [47:0] dreal;
    logic signed [31:0] field;
  } cell_report_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [IN_DW-1:0]     in_tdata;
  logic                 in_tuser;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [OUT_DW-1:0]    out_tdata;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IW-1:0]    cfg_index;
  logic [CFG_DW-1:0]    cfg_data;

  fdtd_1d_debye_step_with_dft_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Grid model state.
  longint flux[NCELL];
  longint efield[NCELL];
  longint hfield[NCELL];
  longint cond_int[NCELL];
  longint relax_int[NCELL];
  longint dft_re[NFREQ][NCELL];
  longint dft_im[NFREQ][NCELL];
  longint ref_dft[2*NFREQ];
  longint edge_hist[4];
  int unsigned step_cnt;

  // Register copies.
  int unsigned slab_start;
  longint ga_q, gb_q, gc_q, decay_q;
  int unsigned src_cell, ref_cell, ref_limit;

  cell_report_t pending_reports[$];
  int unsigned  mismatch_cnt;
  bit           stall_enable;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit well beyond the slowest correct run.
  initial begin
    #250_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic longint sat_q32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint sat_q48(input longint v);
    if (v > 64'sd140737488355327) return 64'sd140737488355327;
    if (v < -64'sd140737488355328) return -64'sd140737488355328;
    return v;
  endfunction

  function automatic longint round_q24(input longint p);
    return (p + HALF_LSB) >>> 24;
  endfunction

  function automatic longint halve_up(input longint d);
    return (d + 1) >>> 1;
  endfunction

  task automatic reset_grid_model();
    for (int c = 0; c < NCELL; c++) begin
      flux[c] = 0; efield[c] = 0; hfield[c] = 0; cond_int[c] = 0; relax_int[c] = 0;
      for (int f = 0; f < NFREQ; f++) begin
        dft_re[f][c] = 0;
        dft_im[f][c] = 0;
      end
    end
    for (int i = 0; i < 2*NFREQ; i++) ref_dft[i] = 0;
    for (int i = 0; i < 4; i++) edge_hist[i] = 0;
    step_cnt = 0;
    slab_start = 256; ga_q = ONE; gb_q = 0; gc_q = 0; decay_q = 0;
    src_cell = 5; ref_cell = 10; ref_limit = 100;
  endtask

  // Advance the model grid by one time step.
  task automatic advance_grid(input grid_item_t it);
    longint cs[NFREQ];
    longint sn[NFREQ];
    longint prev, h, e, ga, gb, gc;
    bit slab;
    cs[0] = it.c0; sn[0] = it.s0;
    cs[1] = it.c1; sn[1] = it.s1;
    cs[2] = it.c2; sn[2] = it.s2;
    if (step_cnt < 65535) step_cnt++;

    // Flux density from the curl of H, then the source.
    prev = 0;
    for (int c = 0; c < NCELL; c++) begin
      h = hfield[c];
      flux[c] = sat_q32(flux[c] + halve_up(prev - h));
      prev = h;
    end
    flux[src_cell] = sat_q32(flux[src_cell] + longint'(it.src));

    // Field and the two loss integrals.
    for (int c = 0; c < NCELL-1; c++) begin
      slab = (c >= slab_start);
      ga = slab ? ga_q : ONE;
      gb = slab ? gb_q : 0;
      gc = slab ? gc_q : 0;
      e = sat_q32(round_q24(ga * (flux[c] - cond_int[c] - relax_int[c])));
      efield[c] = e;
      cond_int[c] = sat_q32(cond_int[c] + round_q24(gb * e));
      relax_int[c] = sat_q32(round_q24(decay_q * relax_int[c] + gc * e));
    end

    // Running DFTs at every cell, and at the reference cell early on.
    for (int c = 0; c < NCELL; c++) begin
      for (int f = 0; f < NFREQ; f++) begin
        dft_re[f][c] = sat_q48(dft_re[f][c] + round_q24(cs[f] * efield[c]));
        dft_im[f][c] = sat_q48(dft_im[f][c] - round_q24(sn[f] * efield[c]));
      end
    end
    if (step_cnt < ref_limit) begin
      e = efield[ref_cell];
      for (int f = 0; f < NFREQ; f++) begin
        ref_dft[2*f]   = sat_q48(ref_dft[2*f] + round_q24(cs[f] * e));
        ref_dft[2*f+1] = sat_q48(ref_dft[2*f+1] - round_q24(sn[f] * e));
      end
    end

    // Absorbing edges use the neighbor value from two steps back.
    efield[0] = edge_hist[1];
    edge_hist[1] = edge_hist[0];
    edge_hist[0] = efield[1];
    efield[NCELL-1] = edge_hist[3];
    edge_hist[3] = edge_hist[2];
    edge_hist[2] = efield[NCELL-2];

    for (int c = 0; c < NCELL-1; c++)
      hfield[c] = sat_q32(hfield[c] + halve_up(efield[c] - efield[c+1]));
  endtask

  // Apply one accepted beat to the model and queue the report it causes.
  task automatic predict_report(input logic mode, input grid_item_t it);
    cell_report_t r;
    if (mode == MODE_STEP) advance_grid(it);
    r = '0;
    r.field = 32'(efield[it.cell_idx]);
    if (it.fsel < NFREQ) begin
      r.dreal = 48'(dft_re[it.fsel][it.cell_idx]);
      r.dimag = 48'(dft_im[it.fsel][it.cell_idx]);
      r.rreal = 48'(ref_dft[2*it.fsel]);
      r.rimag = 48'(ref_dft[2*it.fsel+1]);
    end
    r.steps = step_cnt[15:0];
    pending_reports.push_back(r);
  endtask

  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 9) < 5) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(20, 150);
  endfunction

  // Send one beat; entered and left just after a falling edge.
  task automatic send_item(input logic mode, input grid_item_t it);
    int unsigned gap;
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {2'b00, it};
    do @(posedge clk); while (!in_tready);
    predict_report(mode, it);
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // One register write; the valid line drops for a cycle before returning.
  task automatic write_reg(input logic [CFG_IW-1:0] idx, input longint unsigned val);
    in_tvalid <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DW-1:0];
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_DIEL_START: slab_start = 32'(val[8:0]);
      CFG_GA:         ga_q = longint'(val[24:0]);
      CFG_GB:         gb_q = longint'(val[24:0]);
      CFG_GC:         gc_q = longint'(val[24:0]);
      CFG_RELAX:      decay_q = longint'(val[24:0]);
      CFG_SRC_CELL:   src_cell = 32'(val[7:0]);
      CFG_REF_CELL:   ref_cell = 32'(val[7:0]);
      default:        ref_limit = 32'(val[15:0]);
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Hold the sender until every predicted report has come back.
  task automatic drain_reports();
    in_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic load_regs(input int unsigned ds, input longint unsigned ga,
                           input longint unsigned gb, input longint unsigned gc,
                           input longint unsigned dec, input int unsigned sc,
                           input int unsigned rc, input int unsigned rl);
    drain_reports();
    write_reg(CFG_DIEL_START, 64'(ds));
    write_reg(CFG_GA, ga);
    write_reg(CFG_GB, gb);
    write_reg(CFG_GC, gc);
    write_reg(CFG_RELAX, dec);
    write_reg(CFG_SRC_CELL, 64'(sc));
    write_reg(CFG_REF_CELL, 64'(rc));
    write_reg(CFG_REF_STEPS, 64'(rl));
  endtask

  function automatic logic signed [25:0] rand_trig();
    return 26'(longint'($urandom_range(0, 2*TRIG_MAX)) - TRIG_MAX);
  endfunction

  function automatic grid_item_t rand_item();
    grid_item_t it;
    int unsigned sel;
    it.c0 = rand_trig(); it.s0 = rand_trig();
    it.c1 = rand_trig(); it.s1 = rand_trig();
    it.c2 = rand_trig(); it.s2 = rand_trig();
    sel = $urandom_range(0, 19);
    if (sel == 0)      it.src = 32'sh7fffffff;
    else if (sel == 1) it.src = 32'sh80000000;
    else if (sel < 5)  it.src = $urandom;
    else               it.src = 32'($urandom_range(0, 1 << 26)) - (32'sd1 <<< 25);
    sel = $urandom_range(0, 9);
    if (sel == 0)      it.cell_idx = src_cell[7:0];
    else if (sel == 1) it.cell_idx = ref_cell[7:0];
    else if (sel == 2) it.cell_idx = ($urandom_range(0, 1) == 1) ? 8'd255 : 8'd0;
    else if (sel == 3) it.cell_idx = 8'($urandom_range(0, 1) + (sel == 3 ? 254 : 0));
    else               it.cell_idx = 8'($urandom_range(0, 255));
    it.fsel = 2'($urandom_range(0, 3));
    return it;
  endfunction

  function automatic grid_item_t quiet_item(input logic [7:0] cidx, input logic [1:0] fs);
    grid_item_t it;
    it = '0;
    it.c0 = 26'sd16777216; it.c1 = -26'sd16777216; it.c2 = 26'sd8388608;
    it.s0 = -26'sd16777216; it.s1 = 26'sd16777216; it.s2 = 26'sd0;
    it.cell_idx = cidx;
    it.fsel = fs;
    return it;
  endfunction

  // Receiver backpressure: mostly ready, short and occasional long stalls.
  initial begin
    int unsigned hold;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!stall_enable) begin
        out_tready <= 1'b1;
      end else if ($urandom_range(0, 9) < 2) begin
        hold = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120)
                                           : $urandom_range(1, 3);
        out_tready <= 1'b0;
        repeat (hold) @(negedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Result checker.
  always @(posedge clk) begin
    cell_report_t got, exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (pending_reports.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: unexpected result beat %h", $time, got);
      end else begin
        exp_r = pending_reports.pop_front();
        if (got.field !== exp_r.field) begin
          mismatch_cnt++;
          $display("%0t: field_value exp %0d got %0d", $time, exp_r.field, got.field);
        end
        if (got.dreal !== exp_r.dreal) begin
          mismatch_cnt++;
          $display("%0t: dft_real exp %0d got %0d", $time, exp_r.dreal, got.dreal);
        end
        if (got.dimag !== exp_r.dimag) begin
          mismatch_cnt++;
          $display("%0t: dft_imag exp %0d got %0d", $time, exp_r.dimag, got.dimag);
        end
        if (got.rreal !== exp_r.rreal) begin
          mismatch_cnt++;
          $display("%0t: ref_real exp %0d got %0d", $time, exp_r.rreal, got.rreal);
        end
        if (got.rimag !== exp_r.rimag) begin
          mismatch_cnt++;
          $display("%0t: ref_imag exp %0d got %0d", $time, exp_r.rimag, got.rimag);
        end
        if (got.steps !== exp_r.steps) begin
          mismatch_cnt++;
          $display("%0t: step_number exp %0d got %0d", $time, exp_r.steps, got.steps);
        end
      end
    end
  end

  // Reads of the cleared grid, every frequency select including the unused one.
  task automatic test_reset_reads();
    for (int fs = 0; fs < 4; fs++) begin
      send_item(MODE_READ, quiet_item(8'd0, 2'(fs)));
      send_item(MODE_READ, quiet_item(8'd255, 2'(fs)));
    end
  endtask

  // Full-scale source pulses in free space, trig at its extremes.
  task automatic test_source_extremes();
    grid_item_t it;
    it = quiet_item(8'd5, 2'd0);
    it.src = 32'sh7fffffff;
    send_item(MODE_STEP, it);
    it.src = 32'sh80000000;
    it.cell_idx = 8'd6;
    send_item(MODE_STEP, it);
    it.src = 32'sh00ffffff;
    it.fsel = 2'd3;
    send_item(MODE_STEP, it);
    send_item(MODE_STEP, quiet_item(8'd4, 2'd1));
    send_item(MODE_READ, quiet_item(8'd10, 2'd2));
  endtask

  // Slab over the whole grid with every gain at its top; source at the edges.
  task automatic test_slab_extremes();
    grid_item_t it;
    load_regs(0, 25'h1ffffff, 25'h1ffffff, 25'h1ffffff, ONE, 0, 255, 65535);
    it = quiet_item(8'd0, 2'd0);
    it.src = 32'sh7fffffff;
    send_item(MODE_STEP, it);
    send_item(MODE_STEP, quiet_item(8'd1, 2'd1));
    load_regs(255, 0, 0, 0, 0, 255, 0, 0);
    it = quiet_item(8'd254, 2'd2);
    it.src = 32'sh80000000;
    send_item(MODE_STEP, it);
    send_item(MODE_STEP, quiet_item(8'd255, 2'd0));
    send_item(MODE_READ, quiet_item(8'd0, 2'd3));
  endtask

  // Random mix, mostly reads, with register changes between phases.
  task automatic test_random_mix(input int unsigned beats);
    for (int n = 0; n < beats; n++) begin
      if (n % 150 == 0) begin
        stall_enable = (n % 300 != 0);
        load_regs($urandom_range(0, 511), $urandom_range(0, 25'h1ffffff),
                  $urandom_range(0, 25'h3fffff), $urandom_range(0, 25'h3fffff),
                  $urandom_range(0, ONE), $urandom_range(0, 255),
                  $urandom_range(0, 255), $urandom_range(0, 65535));
        if ($urandom_range(0, 1) == 1) write_reg(CFG_DIEL_START, $urandom_range(100, 256));
        if ($urandom_range(0, 1) == 1) write_reg(CFG_GA, ONE);
      end
      send_item(($urandom_range(0, 3) == 0) ? MODE_STEP : MODE_READ, rand_item());
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = 1'b0;
    in_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mismatch_cnt = 0;
    stall_enable = 1'b1;
    reset_grid_model();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_reads();
    test_source_extremes();
    test_slab_extremes();
    test_random_mix(1150);

    drain_reports();
    repeat (20) @(posedge clk);
    if (mismatch_cnt == 0 && pending_reports.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
